### hw/rtl/ihexd_pkg.sv
// ----------------------------------------------------------------------------
// ihexd_pkg: shared constants, types and helpers
// Codes, reset values and request types of the Intel HEX record decoder.
// ----------------------------------------------------------------------------
package ihexd_pkg;

	localparam int MAX_RECORD_DEF = 32;

	localparam int IMG_SIZE_W = 17;
	localparam logic [IMG_SIZE_W-1:0] IMG_SIZE_RST = 17'h10000;
	localparam logic REG_IMAGE_SIZE = 1'b0;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_ERR = 1'b1;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [1:0] VER_DATA = 2'd0;
	localparam logic [1:0] VER_END  = 2'd1;
	localparam logic [1:0] VER_ERR  = 2'd2;

	localparam logic [9:0]  POS_MAX   = 10'd1023;
	localparam logic [10:0] HDR_LAST  = 11'd10;
	localparam logic [10:0] HDR_NEED  = 11'd11;
	localparam logic [8:0]  WORD_MARK = 9'h100;

	typedef struct packed {
		logic       fin;
		logic       at_end;
		logic [1:0] verdict;
		logic [7:0] count;
		logic [15:0] addr;
	} line_rpt_t;

	typedef struct packed {
		logic       we;
		logic [7:0] idx;
		logic [7:0] data;
	} buf_wr_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
		return r;
	endfunction

endpackage

### hw/rtl/intel_hex_record_decoder_core.sv
// ----------------------------------------------------------------------------
// intel_hex_record_decoder_core: Intel HEX record decoder
// Input channel item_valid/item_stall carries one character (operation 0)
// or end of stream (operation 1). Output channel result_valid/result_stall
// carries word writes (kind 0, value 0x100 + byte) and one final status
// (kind 1). A character is taken every cycle while a line is parsed, also
// while a finished request still waits at the output. At a newline the
// line is judged in the same cycle; a good data record of N bytes then
// holds the input while the buffer memory is read one entry per cycle
// through its single read port, pausing while a stalled output request
// waits. A status result holds the input until the output is free.
// After the status, every input is taken and dropped until reset.
// Reset clears the parser and sequencer and sets image_size to 65536;
// the buffer memory needs no clearing. A stalled output request holds
// its payload; the drain pauses behind it.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder_core import ihexd_pkg::*; #(
	parameter int MAX_RECORD = MAX_RECORD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        operation,
	input  logic [7:0]  character,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [15:0] word_address,
	output logic [8:0]  word_value,
	output logic        status,
	output logic        last
);

	localparam int IDX_W = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;

	logic [IMG_SIZE_W-1:0] image_size_q;
	logic                  parse_en;
	logic                  take;
	line_rpt_t             rpt;
	buf_wr_t               wr;
	logic                  re;
	logic [IDX_W-1:0]      ridx;
	logic [7:0]            rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IMAGE_SIZE) ?
		{{(32-IMG_SIZE_W){1'b0}}, image_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= IMG_SIZE_RST;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_IMAGE_SIZE) begin
			image_size_q <= pwdata[IMG_SIZE_W-1:0];
		end
	end

	assign take = item_valid && !item_stall && parse_en;

	ihexd_parse #(.MAX_RECORD(MAX_RECORD)) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.operation  (operation),
		.character  (character),
		.image_size (image_size_q),
		.rpt        (rpt),
		.wr         (wr)
	);

	ihexd_buf #(.MAX_RECORD(MAX_RECORD), .IDX_W(IDX_W)) u_buf (
		.clk   (clk),
		.wr    (wr),
		.re    (re),
		.ridx  (ridx),
		.rdata (rdata)
	);

	ihexd_seq #(.MAX_RECORD(MAX_RECORD), .IDX_W(IDX_W)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.rpt          (rpt),
		.parse_en     (parse_en),
		.item_stall   (item_stall),
		.re           (re),
		.ridx         (ridx),
		.rdata        (rdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.word_address (word_address),
		.word_value   (word_value),
		.status       (status),
		.last         (last)
	);

endmodule

### hw/rtl/ihexd_buf.sv
// ----------------------------------------------------------------------------
// ihexd_buf: record data buffer
// One write port from the parser, one registered read port for the drain.
// ----------------------------------------------------------------------------
module ihexd_buf import ihexd_pkg::*; #(
	parameter int MAX_RECORD = MAX_RECORD_DEF,
	parameter int IDX_W      = 5
) (
	input  logic             clk,
	input  buf_wr_t          wr,
	input  logic             re,
	input  logic [IDX_W-1:0] ridx,
	output logic [7:0]       rdata
);

	logic [7:0] mem [MAX_RECORD];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.idx[IDX_W-1:0]] <= wr.data;
		end
		if (re) begin
			rdata <= mem[ridx];
		end
	end

endmodule

### hw/rtl/ihexd_parse.sv
// ----------------------------------------------------------------------------
// ihexd_parse: line parser
// Decodes hex pairs of one line, stores data bytes and judges the line.
// ----------------------------------------------------------------------------
module ihexd_parse import ihexd_pkg::*; #(
	parameter int MAX_RECORD = MAX_RECORD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic                  operation,
	input  logic [7:0]            character,
	input  logic [IMG_SIZE_W-1:0] image_size,
	output line_rpt_t             rpt,
	output buf_wr_t               wr
);

	logic [9:0]  pos_q;
	logic [3:0]  hi_q;
	logic [7:0]  cnt_q;
	logic [15:0] addr_q;
	logic [7:0]  type_q;
	logic [7:0]  sum_q;
	logic        bad_q;
	logic        pend_q;

	logic [4:0]  hv;
	logic        dig_bad;
	logic [3:0]  nib;
	logic [7:0]  byte_val;
	logic [10:0] lim;
	logic [10:0] need;
	logic        in_range;
	logic [9:0]  pos_m2;
	logic [8:0]  k;
	logic [8:0]  j;
	logic [16:0] span;
	logic        is_char;
	logic        is_nl;
	logic        step;

	always_comb begin
		hv       = hex_value(character);
		dig_bad  = hv[4];
		nib      = dig_bad ? 4'd0 : hv[3:0];
		byte_val = {hi_q, nib};
		lim      = HDR_LAST + {2'b00, cnt_q, 1'b0};
		need     = HDR_NEED + {2'b00, cnt_q, 1'b0};
		in_range = (pos_q != 10'd0) && ({1'b0, pos_q} <= lim);
		pos_m2   = pos_q - 10'd2;
		k        = pos_m2[9:1];
		j        = k - 9'd4;
		span     = {1'b0, addr_q} + {9'd0, cnt_q};
		is_char  = take && (operation == OP_CHAR);
		is_nl    = is_char && (character == CH_NL);
		step     = is_char && !is_nl;
	end

	always_comb begin
		rpt.fin    = take && ((operation == OP_END) || is_nl);
		rpt.at_end = (operation == OP_END);
		rpt.count  = cnt_q;
		rpt.addr   = addr_q;
		if (operation == OP_END && !pend_q) begin
			rpt.verdict = VER_END;
		end else if (bad_q || ({1'b0, pos_q} < need) || (sum_q != 8'd0) ||
				(type_q > 8'd1)) begin
			rpt.verdict = VER_ERR;
		end else if (type_q == 8'd1) begin
			rpt.verdict = VER_END;
		end else if (span > image_size) begin
			rpt.verdict = VER_ERR;
		end else begin
			rpt.verdict = VER_DATA;
		end
	end

	always_comb begin
		wr.we   = step && in_range && !pos_q[0] && (k >= 9'd4) &&
			(j < {1'b0, cnt_q}) && (j < 9'(MAX_RECORD));
		wr.idx  = j[7:0];
		wr.data = byte_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hi_q   <= '0;
			cnt_q  <= '0;
			addr_q <= '0;
			type_q <= '0;
			sum_q  <= '0;
			bad_q  <= 1'b0;
			pend_q <= 1'b0;
		end else if (rpt.fin) begin
			pos_q  <= '0;
			hi_q   <= '0;
			cnt_q  <= '0;
			addr_q <= '0;
			type_q <= '0;
			sum_q  <= '0;
			bad_q  <= 1'b0;
			pend_q <= 1'b0;
		end else if (step) begin
			pend_q <= 1'b1;
			if (pos_q == 10'd0) begin
				if (character != CH_COLON) bad_q <= 1'b1;
			end else if (in_range) begin
				if (dig_bad) bad_q <= 1'b1;
				if (pos_q[0]) begin
					hi_q <= nib;
				end else begin
					sum_q <= sum_q + byte_val;
					case (k)
						9'd0: begin
							cnt_q <= byte_val;
							if (byte_val > 8'(MAX_RECORD)) bad_q <= 1'b1;
						end
						9'd1: addr_q[15:8] <= byte_val;
						9'd2: addr_q[7:0] <= byte_val;
						9'd3: type_q <= byte_val;
						default: ;
					endcase
				end
			end
			if (pos_q != POS_MAX) pos_q <= pos_q + 10'd1;
		end
	end

endmodule

### hw/rtl/ihexd_seq.sv
// ----------------------------------------------------------------------------
// ihexd_seq: result sequencer
// Drains buffered bytes as word writes, issues the final status.
// ----------------------------------------------------------------------------
module ihexd_seq import ihexd_pkg::*; #(
	parameter int MAX_RECORD = MAX_RECORD_DEF,
	parameter int IDX_W      = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  line_rpt_t        rpt,
	output logic             parse_en,
	output logic             item_stall,
	output logic             re,
	output logic [IDX_W-1:0] ridx,
	input  logic [7:0]       rdata,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             kind,
	output logic [15:0]      word_address,
	output logic [8:0]       word_value,
	output logic             status,
	output logic             last
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DRAIN  = 2'd1;
	localparam logic [1:0] ST_STATUS = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]  st_q;
	logic [7:0]  cnt_q;
	logic [15:0] base_q;
	logic        at_end_q;
	logic        err_q;
	logic [7:0]  issue_q;
	logic        rd_pending_s1;
	logic [15:0] addr_s1;
	logic        last_s1;

	logic out_free;
	logic consume;
	logic issue;
	logic drain_done;

	always_comb begin
		out_free   = !result_valid || !result_stall;
		consume    = rd_pending_s1 && out_free;
		issue      = (st_q == ST_DRAIN) && (issue_q != cnt_q) &&
			(!rd_pending_s1 || consume);
		drain_done = (st_q == ST_DRAIN) && (issue_q == cnt_q) &&
			(!rd_pending_s1 || consume);
		parse_en   = (st_q == ST_IDLE);
		item_stall = (st_q == ST_DRAIN) || (st_q == ST_STATUS);
		re         = issue;
		ridx       = issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			cnt_q         <= '0;
			base_q        <= '0;
			at_end_q      <= 1'b0;
			err_q         <= 1'b0;
			issue_q       <= '0;
			rd_pending_s1 <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (rpt.fin) begin
						cnt_q    <= rpt.count;
						base_q   <= rpt.addr;
						at_end_q <= rpt.at_end;
						issue_q  <= '0;
						case (rpt.verdict)
							VER_DATA: begin
								err_q <= 1'b0;
								if (rpt.count != 8'd0) st_q <= ST_DRAIN;
								else if (rpt.at_end) st_q <= ST_STATUS;
							end
							VER_END: begin
								err_q <= 1'b0;
								st_q  <= ST_STATUS;
							end
							default: begin
								err_q <= 1'b1;
								st_q  <= ST_STATUS;
							end
						endcase
					end
				end
				ST_DRAIN: begin
					if (issue) issue_q <= issue_q + 8'd1;
					if (drain_done) st_q <= at_end_q ? ST_STATUS : ST_IDLE;
				end
				ST_STATUS: begin
					if (out_free) st_q <= ST_DONE;
				end
				default: st_q <= ST_DONE;
			endcase
			if (issue) rd_pending_s1 <= 1'b1;
			else if (consume) rd_pending_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= base_q + {8'd0, issue_q};
			last_s1 <= !at_end_q && ((issue_q + 8'd1) == cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= consume || (st_q == ST_STATUS);
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			kind         <= KIND_WRITE;
			word_address <= addr_s1;
			word_value   <= WORD_MARK | {1'b0, rdata};
			status       <= STAT_OK;
			last         <= last_s1;
		end else if (out_free && st_q == ST_STATUS) begin
			kind         <= KIND_STATUS;
			word_address <= '0;
			word_value   <= '0;
			status       <= err_q ? STAT_ERR : STAT_OK;
			last         <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_rd_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pending_s1 |-> (st_q == ST_DRAIN))
		else $error("read in flight outside drain");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DRAIN) |-> (issue_q <= cnt_q))
		else $error("drain index past record count");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_STATUS) |-> last)
		else $error("status request without last");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE) |=> (st_q == ST_DONE))
		else $error("left finished state");
`endif

endmodule

### dv/tb_intel_hex_record_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intel_hex_record_decoder_core: self-checking bench for the HEX decoder
// Feeds Intel HEX text one character per request, with random gaps and
// output stalls. The bench tracks the parser state itself and compares every
// image write and the final status. It also walks image_size through its
// extremes over the APB port. Since the image can end only once per reset,
// each run closes it by one randomly chosen ending: end record, end of
// stream, or one of the format and range faults. Requests that follow are
// checked to cause nothing.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_decoder_core;
	import ihexd_pkg::*;

	localparam int          RUN_LIMIT     = 500_000;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          TAIL_CYCLES   = 40;
	localparam int          RANDOM_CHARS  = 100;
	localparam logic [7:0]  CH_CR         = 8'h0D;
	localparam logic [2:0]  ADDR_IMAGE_SIZE = 3'(4 * int'(REG_IMAGE_SIZE));

	typedef enum int {
		FIN_EOF_IDLE,
		FIN_EOF_PENDING,
		FIN_END_RECORD,
		FIN_BAD_SUM,
		FIN_SHORT_LINE,
		FIN_NO_COLON,
		FIN_BAD_DIGIT,
		FIN_BAD_TYPE,
		FIN_LONG_RECORD,
		FIN_OUT_OF_RANGE
	} finish_case_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] addr;
		logic [8:0]  value;
		logic        status;
		logic        last;
	} image_update_t;

	class hex_image_tracker;
		logic [16:0]   image_words;
		int unsigned   col;
		logic [3:0]    hi_nib;
		logic [7:0]    rec_len;
		logic [15:0]   rec_addr;
		logic [7:0]    rec_type;
		logic [7:0]    rec_sum;
		logic [7:0]    rec_bytes [MAX_RECORD_DEF];
		logic          line_bad;
		logic          line_open;
		logic          image_done;
		image_update_t updates_due[$];
		int unsigned   fails;
		int unsigned   writes_checked;
		logic          final_status;

		function new();
			image_words = IMG_SIZE_RST;
			foreach (rec_bytes[i]) rec_bytes[i] = '0;
			image_done = 1'b0;
			fails = 0;
			writes_checked = 0;
			final_status = STAT_OK;
			restart_line();
		endfunction

		static function int nibble_of(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
			return 16;
		endfunction

		function void restart_line();
			col = 0;
			hi_nib = '0;
			rec_len = '0;
			rec_addr = '0;
			rec_type = '0;
			rec_sum = '0;
			line_bad = 1'b0;
			line_open = 1'b0;
		endfunction

		function void add_update(logic k, logic [15:0] a, logic [8:0] v, logic s, logic l);
			updates_due.push_back(image_update_t'{k, a, v, s, l});
			if (k == KIND_STATUS) image_done = 1'b1;
		endfunction

		function void take_char(logic [7:0] c);
			int         v;
			int         k;
			logic [7:0] b;
			line_open = 1'b1;
			if (col == 0) begin
				if (c != CH_COLON) line_bad = 1'b1;
			end else if (col <= 10 + 2 * rec_len) begin
				v = nibble_of(c);
				if (v > 15) begin
					line_bad = 1'b1;
					v = 0;
				end
				if (col % 2 == 1) begin
					hi_nib = 4'(v);
				end else begin
					b = {hi_nib, 4'(v)};
					k = (col - 2) / 2;
					rec_sum += b;
					if (k == 0) begin
						rec_len = b;
						if (b > MAX_RECORD_DEF) line_bad = 1'b1;
					end else if (k == 1) begin
						rec_addr[15:8] = b;
					end else if (k == 2) begin
						rec_addr[7:0] = b;
					end else if (k == 3) begin
						rec_type = b;
					end else if (k - 4 < rec_len && k - 4 < MAX_RECORD_DEF) begin
						rec_bytes[k - 4] = b;
					end
				end
			end
			if (col < POS_MAX) col++;
		endfunction

		function void close_line(bit at_end);
			logic [1:0]  verdict;
			int unsigned need;
			need = 11 + 2 * rec_len;
			if (line_bad || col < need || rec_sum != 0 || rec_type > 1)
				verdict = VER_ERR;
			else if (rec_type == 1)
				verdict = VER_END;
			else if (int'(rec_addr) + int'(rec_len) > int'(image_words))
				verdict = VER_ERR;
			else
				verdict = VER_DATA;
			if (verdict == VER_DATA) begin
				for (int i = 0; i < rec_len; i++)
					add_update(KIND_WRITE, 16'(rec_addr + i), WORD_MARK + 9'(rec_bytes[i]),
						STAT_OK, !at_end && i == rec_len - 1);
				if (at_end) add_update(KIND_STATUS, '0, '0, STAT_OK, 1'b1);
			end else begin
				add_update(KIND_STATUS, '0, '0, verdict == VER_ERR ? STAT_ERR : STAT_OK, 1'b1);
			end
			restart_line();
		endfunction

		function void take_request(logic op, logic [7:0] c);
			if (image_done) return;
			if (op == OP_END) begin
				if (line_open) close_line(1'b1);
				else add_update(KIND_STATUS, '0, '0, STAT_OK, 1'b1);
			end else if (c == CH_NL) begin
				close_line(1'b0);
			end else begin
				take_char(c);
			end
		endfunction

		function void check_result(image_update_t got);
			image_update_t want;
			if (updates_due.size() == 0) begin
				$error("result with nothing expected: kind %0d address %h value %h",
					got.kind, got.addr, got.value);
				fails++;
				return;
			end
			want = updates_due.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				fails++;
			end
			if (got.addr !== want.addr) begin
				$error("word_address: expected %h, got %h", want.addr, got.addr);
				fails++;
			end
			if (got.value !== want.value) begin
				$error("word_value: expected %h, got %h", want.value, got.value);
				fails++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				fails++;
			end
			if (want.kind == KIND_WRITE) writes_checked++;
			else final_status = want.status;
		endfunction
	endclass

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic        operation    = OP_CHAR;
	logic [7:0]  character    = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        kind;
	logic [15:0] word_address;
	logic [8:0]  word_value;
	logic        status;
	logic        last;

	hex_image_tracker tracker;
	bit               no_gaps = 1'b0;
	logic [16:0]      image_words_now = IMG_SIZE_RST;
	logic [7:0]       line_chars[$];
	logic [7:0]       line_sum;
	int unsigned      body_chars = 0;
	int unsigned      lines_sent = 0;
	int unsigned      cycles = 0;

	intel_hex_record_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.character    (character),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.word_address (word_address),
		.word_value   (word_value),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				tracker.take_request(operation, character);
			if (result_valid && !result_stall)
				tracker.check_result(image_update_t'{kind, word_address, word_value, status, last});
		end
	end

	initial begin : result_sink
		int hold;
		@(posedge clk);
		forever begin
			hold = no_gaps ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
		if (n < 10) return 8'h30 + {4'h0, n};
		return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do c = 8'($urandom); while (c == CH_NL);
		return c;
	endfunction

	function automatic void push_byte(input logic [7:0] b, input bit lower);
		line_chars.push_back(hex_digit(b[7:4], lower));
		line_chars.push_back(hex_digit(b[3:0], lower));
		line_sum += b;
	endfunction

	function automatic void build_record(input int count, input logic [15:0] addr,
		input logic [7:0] rtype, input bit lower, input logic [7:0] sum_skew);
		line_chars.delete();
		line_chars.push_back(CH_COLON);
		line_sum = '0;
		push_byte(8'(count), lower);
		push_byte(addr[15:8], lower);
		push_byte(addr[7:0], lower);
		push_byte(rtype, lower);
		repeat (count) push_byte(8'($urandom), lower);
		push_byte(8'(-line_sum) + sum_skew, lower);
	endfunction

	function automatic logic [15:0] pick_address(input int count);
		int hi;
		hi = int'(image_words_now) - count;
		if (hi > 65535) hi = 65535;
		case ($urandom_range(0, 7))
			0: return 16'(hi);
			1: return 16'd0;
			default: return 16'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic logic [16:0] pick_image_words();
		case ($urandom_range(0, 3))
			0: return IMG_SIZE_RST;
			1: return '1;
			default: return 17'($urandom_range(64, 65536));
		endcase
	endfunction

	task automatic send_request(input logic op, input logic [7:0] ch);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		character <= ch;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_line(input bit newline, input int tail);
		foreach (line_chars[i]) send_request(OP_CHAR, line_chars[i]);
		body_chars += line_chars.size();
		repeat (tail) send_request(OP_CHAR, ($urandom_range(0, 3) == 0) ? CH_CR : junk_char());
		if (newline) begin
			send_request(OP_CHAR, CH_NL);
			body_chars++;
		end
		lines_sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (tracker.updates_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_image_size(input logic [16:0] words);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_IMAGE_SIZE;
		pwdata <= {15'd0, words};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.image_words = words;
		image_words_now = words;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {15'd0, words}) begin
			$error("image_size readback: expected %h, got %h", {15'd0, words}, prdata);
			tracker.fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic finish_image(input finish_case_t fin);
		int         count;
		int         pos;
		int         keep;
		int         lo;
		logic [7:0] c;
		count = $urandom_range(1, 8);
		build_record(count, pick_address(count), 8'h00, $urandom_range(0, 1), 8'h00);
		case (fin)
			FIN_EOF_IDLE: begin
				send_request(OP_END, 8'($urandom));
			end
			FIN_EOF_PENDING: begin
				send_line(1'b0, $urandom_range(0, 2));
				send_request(OP_END, 8'($urandom));
			end
			FIN_END_RECORD: begin
				build_record($urandom_range(0, 4), 16'($urandom), 8'h01, $urandom_range(0, 1), 8'h00);
				send_line(1'b1, 0);
			end
			FIN_BAD_SUM: begin
				build_record(count, pick_address(count), 8'h00, $urandom_range(0, 1),
					8'($urandom_range(1, 255)));
				send_line(1'b1, 0);
			end
			FIN_SHORT_LINE: begin
				keep = $urandom_range(0, line_chars.size() - 1);
				while (line_chars.size() > keep) void'(line_chars.pop_back());
				send_line(1'b1, 0);
			end
			FIN_NO_COLON: begin
				do c = junk_char(); while (c == CH_COLON);
				line_chars[0] = c;
				send_line(1'b1, 0);
			end
			FIN_BAD_DIGIT: begin
				pos = $urandom_range(1, line_chars.size() - 1);
				do c = junk_char(); while (hex_image_tracker::nibble_of(c) < 16);
				line_chars[pos] = c;
				send_line(1'b1, 0);
			end
			FIN_BAD_TYPE: begin
				build_record(count, 16'($urandom), 8'($urandom_range(2, 255)),
					$urandom_range(0, 1), 8'h00);
				send_line(1'b1, 0);
			end
			FIN_LONG_RECORD: begin
				build_record($urandom_range(MAX_RECORD_DEF + 1, 255), 16'($urandom), 8'h00,
					$urandom_range(0, 1), 8'h00);
				send_line(1'b1, 0);
			end
			default: begin
				settle();
				program_image_size(17'($urandom_range(0, 65536)));
				count = $urandom_range(1, MAX_RECORD_DEF);
				lo = int'(image_words_now) - count + 1;
				if (lo < 0) lo = 0;
				build_record(count, 16'($urandom_range(lo, 65535)), 8'h00, $urandom_range(0, 1), 8'h00);
				send_line(1'b1, 0);
			end
		endcase
	endtask

	initial begin : stimulus
		finish_case_t fin;
		int           count;
		int           tail;
		int           lines;
		int           long_line;
		int unsigned  first_chars;
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		program_image_size(IMG_SIZE_RST);

		build_record(0, 16'h0000, 8'h00, 1'b0, 8'h00);
		send_line(1'b1, 0);
		build_record(MAX_RECORD_DEF, 16'hFFE0, 8'h00, 1'b0, 8'h00);
		send_line(1'b1, 0);
		build_record(1, 16'h0000, 8'h00, 1'b1, 8'h00);
		line_chars.push_back(CH_CR);
		send_line(1'b1, 0);
		build_record(2, 16'h8001, 8'h00, 1'b1, 8'h00);
		line_chars.push_back(8'h00);
		line_chars.push_back(8'hFF);
		line_chars.push_back(8'h80);
		line_chars.push_back(CH_CR);
		send_line(1'b1, 0);
		settle();
		program_image_size('1);
		build_record(4, 16'hFFFE, 8'h00, 1'b0, 8'h00);
		send_line(1'b1, 0);
		settle();
		program_image_size('0);
		build_record(0, 16'h0000, 8'h00, 1'b1, 8'h00);
		send_line(1'b1, 0);

		first_chars = body_chars;
		long_line = $urandom_range(1, 3);
		lines = 0;
		while (body_chars - first_chars < RANDOM_CHARS) begin
			if (lines % 6 == 0) begin
				settle();
				program_image_size(pick_image_words());
			end else if ($urandom_range(0, 9) == 0) begin
				settle();
			end
			if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: count = $urandom_range(0, 8);
				7, 8: count = $urandom_range(9, MAX_RECORD_DEF - 1);
				default: count = MAX_RECORD_DEF;
			endcase
			build_record(count, pick_address(count), 8'h00, $urandom_range(0, 1), 8'h00);
			if (lines == long_line) tail = 24 + $urandom_range(0, 8);
			else if ($urandom_range(0, 9) < 3) tail = $urandom_range(1, 4);
			else tail = 0;
			send_line(1'b1, tail);
			lines++;
		end

		settle();
		fin = finish_case_t'($urandom_range(0, int'(FIN_OUT_OF_RANGE)));
		finish_image(fin);
		repeat (10) send_request(1'($urandom_range(0, 1)), 8'($urandom));

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d lines, %0d line characters and %0d checked image writes.",
			lines_sent, body_chars, tracker.writes_checked);
		$display("Image closed by %s, final status %0d.", fin.name(), tracker.final_status);
		if (tracker.fails == 0 && tracker.updates_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
